// ===== rtl/urdp_pkg.sv =====
package urdp_pkg;

  localparam int POOL_DEPTH = 1024;
  localparam int IDX_W      = $clog2(POOL_DEPTH);
  localparam int CNT_W      = IDX_W + 1;

  localparam int WORD_W     = 64;
  localparam int BIT_CNT_W  = $clog2(WORD_W);

  localparam int LOW_W      = 32;
  localparam int SPAN_W     = 10;
  localparam int LIMIT_W    = 11;
  localparam int VAL_W      = 33;
  localparam int STATUS_W   = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // wide enough for size, count and limit compares
  localparam int CALC_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  localparam logic [STATUS_W-1:0] STAT_DRAWN     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RESTART   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_VALUE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_SPAN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAW_LIMIT = 2'd2;

  localparam logic REQ_RESTART = 1'b0;

endpackage

// ===== rtl/urdp_in_if.sv =====
interface urdp_in_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [urdp_pkg::WORD_W-1:0] random_word;

  modport source (output valid, output req_type, output random_word, input ready);
  modport sink   (input valid, input req_type, input random_word, output ready);
endinterface

// ===== rtl/urdp_out_if.sv =====
interface urdp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [urdp_pkg::VAL_W-1:0]   value;
  logic        [urdp_pkg::STATUS_W-1:0] status;
  logic                                last_draw;

  modport source (output valid, output value, output status, output last_draw, input ready);
  modport sink   (input valid, input value, input status, input last_draw, output ready);
endinterface

// ===== rtl/urdp_cfg_if.sv =====
interface urdp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [urdp_pkg::CFG_IDX_W-1:0]  index;
  logic [urdp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/urdp_mod.sv =====
// Restoring remainder, one dividend bit per cycle, MSB first.
module urdp_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [urdp_pkg::WORD_W-1:0] dividend,
  input  logic [urdp_pkg::CNT_W-1:0]  divisor,
  output logic                        done,
  output logic [urdp_pkg::IDX_W-1:0]  remainder
);

  logic [urdp_pkg::WORD_W-1:0]    word_r;
  logic [urdp_pkg::CNT_W-1:0]     div_r;
  logic [urdp_pkg::CNT_W-1:0]     rem_r;
  logic [urdp_pkg::CNT_W-1:0]     rem_nxt;
  logic [urdp_pkg::CNT_W:0]       trial;
  logic [urdp_pkg::BIT_CNT_W-1:0] bit_r;
  logic                           busy_r;
  logic                           done_r;

  always_comb begin
    trial = {rem_r, word_r[urdp_pkg::WORD_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = urdp_pkg::CNT_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = trial[urdp_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      bit_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        bit_r  <= '0;
        word_r <= dividend;
        div_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        word_r <= {word_r[urdp_pkg::WORD_W-2:0], 1'b0};
        bit_r  <= bit_r + 1'b1;
        if (bit_r == urdp_pkg::BIT_CNT_W'(urdp_pkg::WORD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r[urdp_pkg::IDX_W-1:0];

endmodule

// ===== rtl/unique_random_draw_pool.sv =====
// Unique random draw pool. A draw (req_type 1) returns low_value plus an offset picked
// from the live pool by random_word mod remaining, never repeating until a restart.
// The 64-bit modulo runs bit-serially, one dividend bit per cycle, and is followed by
// two pool reads and one write on the pool memory (one read port, one write port).
// A restart (req_type 0) rewrites min(pool_span+1, 1024) pool entries at one per cycle.
// An exhausted draw skips the modulo and answers with the exhausted status.
// After reset the block runs a pass that loads all 1024 pool entries with 0..1023 and
// accepts no item meanwhile; configuration writes are taken at any time. A result
// waiting in the output register does not stop the next item from being accepted.
module unique_random_draw_pool (
  input  logic              clk,
  input  logic              rst_n,
  urdp_in_if.sink           in_if,
  urdp_out_if.source        out_if,
  urdp_cfg_if.sink          cfg_if
);

  localparam logic [2:0] S_FILL    = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_DIV     = 3'd2;
  localparam logic [2:0] S_RD_IDX  = 3'd3;
  localparam logic [2:0] S_RD_LAST = 3'd4;
  localparam logic [2:0] S_WR      = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  localparam int IDX_W  = urdp_pkg::IDX_W;
  localparam int CNT_W  = urdp_pkg::CNT_W;
  localparam int CALC_W = urdp_pkg::CALC_W;
  localparam int VAL_W  = urdp_pkg::VAL_W;

  logic [2:0] state_r, state_nxt;

  logic signed [urdp_pkg::LOW_W-1:0] low_value_r;
  logic [urdp_pkg::SPAN_W-1:0]       pool_span_r;
  logic [urdp_pkg::LIMIT_W-1:0]      draw_limit_r;

  logic [CNT_W-1:0] drawn_count_r;
  logic [CNT_W-1:0] fill_cnt_r;
  logic [CNT_W-1:0] fill_size_r;
  logic             fill_report_r;
  logic [CNT_W-1:0] remaining_r;
  logic [IDX_W-1:0] idx_r;

  logic [VAL_W-1:0]              res_value_r;
  logic [urdp_pkg::STATUS_W-1:0] res_status_r;
  logic                          res_last_r;

  logic                          out_valid_r;
  logic [VAL_W-1:0]              out_value_r;
  logic [urdp_pkg::STATUS_W-1:0] out_status_r;
  logic                          out_last_r;

  logic [IDX_W-1:0] pool_mem [urdp_pkg::POOL_DEPTH];
  logic [IDX_W-1:0] rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] wr_data;
  logic             wr_en;

  logic [CALC_W-1:0] span_p1;
  logic [CALC_W-1:0] size_calc;
  logic [CNT_W-1:0]  live_size;
  logic [CALC_W-1:0] drawn_ext;
  logic [CALC_W-1:0] limit_ext;
  logic              exhausted;
  logic [CNT_W-1:0]  remaining;
  logic [CNT_W-1:0]  last_cnt;
  logic [IDX_W-1:0]  last_addr;
  logic              in_fire;
  logic              out_load;
  logic              mod_start;
  logic              mod_done;
  logic [IDX_W-1:0]  mod_rem;

  // ---- configuration ----
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_value_r  <= '0;
      pool_span_r  <= urdp_pkg::SPAN_W'(1023);
      draw_limit_r <= urdp_pkg::LIMIT_W'(1024);
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        urdp_pkg::CFG_LOW_VALUE:  low_value_r  <= cfg_if.data;
        urdp_pkg::CFG_POOL_SPAN:  pool_span_r  <= cfg_if.data[urdp_pkg::SPAN_W-1:0];
        urdp_pkg::CFG_DRAW_LIMIT: draw_limit_r <= cfg_if.data[urdp_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- live pool size and draw checks ----
  always_comb begin
    span_p1   = CALC_W'(pool_span_r) + CALC_W'(1);
    size_calc = (span_p1 > CALC_W'(urdp_pkg::POOL_DEPTH)) ?
                CALC_W'(urdp_pkg::POOL_DEPTH) : span_p1;
    live_size = size_calc[CNT_W-1:0];
    drawn_ext = CALC_W'(drawn_count_r);
    limit_ext = CALC_W'(draw_limit_r);
    exhausted = (drawn_ext >= limit_ext) || (drawn_ext >= size_calc);
    remaining = live_size - drawn_count_r;
    last_cnt  = remaining_r - CNT_W'(1);
    last_addr = last_cnt[IDX_W-1:0];
  end

  assign in_if.ready = (state_r == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_if.ready);
  assign mod_start   = in_fire && (in_if.req_type != urdp_pkg::REQ_RESTART) && !exhausted;

  urdp_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (in_if.random_word),
    .divisor   (remaining),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // ---- sequencer ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_FILL: begin
        if (fill_cnt_r + CNT_W'(1) == fill_size_r) begin
          state_nxt = fill_report_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (in_if.req_type == urdp_pkg::REQ_RESTART) begin
            state_nxt = S_FILL;
          end else if (exhausted) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV:     if (mod_done) state_nxt = S_RD_IDX;
      S_RD_IDX:  state_nxt = S_RD_LAST;
      S_RD_LAST: state_nxt = S_WR;
      S_WR:      state_nxt = S_DONE;
      S_DONE:    if (out_load) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_FILL;
      fill_cnt_r    <= '0;
      fill_size_r   <= CNT_W'(urdp_pkg::POOL_DEPTH);
      fill_report_r <= 1'b0;
      drawn_count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FILL) begin
        fill_cnt_r <= fill_cnt_r + CNT_W'(1);
      end
      if (in_fire) begin
        if (in_if.req_type == urdp_pkg::REQ_RESTART) begin
          fill_cnt_r    <= '0;
          fill_size_r   <= live_size;
          fill_report_r <= 1'b1;
          drawn_count_r <= '0;
          res_status_r  <= urdp_pkg::STAT_RESTART;
          res_value_r   <= '0;
          res_last_r    <= 1'b0;
        end else if (exhausted) begin
          res_status_r  <= urdp_pkg::STAT_EXHAUSTED;
          res_value_r   <= '0;
          res_last_r    <= 1'b0;
        end else begin
          remaining_r   <= remaining;
        end
      end
      if (state_r == S_DIV && mod_done) begin
        idx_r <= mod_rem;
      end
      if (state_r == S_RD_LAST) begin
        // rd_data_r holds pool[idx] here
        res_value_r <= {low_value_r[urdp_pkg::LOW_W-1], low_value_r} + VAL_W'(rd_data_r);
      end
      if (state_r == S_WR) begin
        drawn_count_r <= drawn_count_r + CNT_W'(1);
        res_status_r  <= urdp_pkg::STAT_DRAWN;
        res_last_r    <= (drawn_ext + CALC_W'(1) == limit_ext) || (remaining_r == CNT_W'(1));
      end
    end
  end

  // ---- pool memory ----
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = rd_data_r;
    rd_addr = idx_r;
    if (state_r == S_FILL) begin
      wr_en   = 1'b1;
      wr_addr = fill_cnt_r[IDX_W-1:0];
      wr_data = fill_cnt_r[IDX_W-1:0];
    end else if (state_r == S_WR) begin
      wr_en   = 1'b1;                 // rd_data_r holds pool[last] here
    end
    if (state_r == S_RD_LAST) begin
      rd_addr = last_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pool_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= pool_mem[rd_addr];
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r  <= 1'b1;
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
      out_last_r   <= res_last_r;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.value     = out_value_r;
  assign out_if.status    = out_status_r;
  assign out_if.last_draw = out_last_r;

  // ---- checks ----
  a_mod_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> state_r == S_DIV)
    else $error("modulo result outside divide phase");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD_IDX |-> CNT_W'(idx_r) < remaining_r)
    else $error("picked index not below remaining count");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WR |=> drawn_count_r == $past(drawn_count_r) + CNT_W'(1))
    else $error("draw count did not advance after a draw");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    drawn_count_r <= CNT_W'(urdp_pkg::POOL_DEPTH))
    else $error("draw count beyond pool depth");

endmodule
